/* src/c3r_pkg.sv */
`timescale 1ns / 1ps

package c3r_pkg;

   localparam int MAX_WIDTH = 1024;
   localparam int ADDR_W = $clog2(MAX_WIDTH);
   localparam int WIDTH_W = 11;
   localparam int ROW_W = 16;
   localparam int CHAN_W = 8;
   localparam int PIX_W = 3 * CHAN_W;
   localparam int COEF_BITS = 8;
   localparam int KROW_W = 3 * COEF_BITS;
   localparam int OUT_W = 19;
   localparam int PROD_W = COEF_BITS + CHAN_W + 1;
   localparam int SUM_W = PROD_W + 4;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 24;
   localparam int WIDTH_RST = 32;
   localparam int HEIGHT_RST = 32;
   localparam logic signed [31:0] CLAMP_HI = 32'sd1000000000;
   localparam logic signed [31:0] CLAMP_LO = -32'sd1000000000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KROW_TOP   = 3'd0,
      CSR_KROW_MID   = 3'd1,
      CSR_KROW_BOT   = 3'd2,
      CSR_IMG_WIDTH  = 3'd3,
      CSR_IMG_HEIGHT = 3'd4
   } csr_idx_type;

   typedef struct packed {
      logic [2:0][KROW_W-1:0] krow;
      logic [WIDTH_W-1:0]     width;
      logic [ROW_W-1:0]       height;
   } cfg_type;

   typedef struct packed {
      logic             valid;
      logic [PIX_W-1:0] px;
      logic [PIX_W-1:0] above;
      logic [PIX_W-1:0] above2;
      logic             emit;
      logic             pass;
      logic             last_col;
      logic             last_row;
   } s1_type;

endpackage

/* src/c3r_req_if.sv */
`timescale 1ns / 1ps

interface c3r_req_if;
   logic                       valid;
   logic                       ready;
   logic [c3r_pkg::CHAN_W-1:0] pixel_chan0;
   logic [c3r_pkg::CHAN_W-1:0] pixel_chan1;
   logic [c3r_pkg::CHAN_W-1:0] pixel_chan2;

   modport source (output valid, output pixel_chan0, output pixel_chan1,
                   output pixel_chan2, input ready);
   modport sink (input valid, input pixel_chan0, input pixel_chan1,
                 input pixel_chan2, output ready);
endinterface

/* src/c3r_rsp_if.sv */
`timescale 1ns / 1ps

interface c3r_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [c3r_pkg::OUT_W-1:0] out_chan0;
   logic [c3r_pkg::OUT_W-1:0] out_chan1;
   logic [c3r_pkg::OUT_W-1:0] out_chan2;
   logic                      row_end;
   logic                      frame_end;

   modport source (output valid, output out_chan0, output out_chan1,
                   output out_chan2, output row_end, output frame_end,
                   input ready);
   modport sink (input valid, input out_chan0, input out_chan1,
                 input out_chan2, input row_end, input frame_end,
                 output ready);
endinterface

/* src/c3r_csr_if.sv */
`timescale 1ns / 1ps

interface c3r_csr_if;
   logic                           valid;
   logic                           ready;
   logic [c3r_pkg::CSR_IDX_W-1:0]  index;
   logic [c3r_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

/* src/conv3x3_relu_rgb.sv */
`timescale 1ns / 1ps

// Streaming 3x3 convolution with ReLU over three 8-bit channels.
// req_ch: one pixel per item, row-major, frame size taken from the
//   image_width / image_height registers; frames follow back to back.
// rsp_ch: one item per full 3x3 window inside the image, carrying the
//   rectified sum per channel plus row_end / frame_end marks. If width
//   or height is below 3, every pixel comes back unchanged.
// csr_ch: register writes (0..2 kernel rows, 3 width, 4 height), always
//   ready; write only while no item is in flight.
// Path of a pixel to its result: pixel reg and line store read, window
//   update, multiply-add into the output reg, one register stage each.
// Throughput: one pixel per cycle while rsp_ch is not stalled; the two
//   line stores take one read and one write each per cycle, with bypass
//   when both hit the same column.
// When rsp_ch stalls, the output register holds and the two stages ahead
//   of it keep filling; req_ch.ready drops once all three are occupied.
// Reset clears counters, window, kernel (to zero) and the frame size (to
//   32 x 32). Line stores are not cleared and need no clearing pass.
module conv3x3_relu_rgb (
   input  logic         clock,
   input  logic         reset,
   c3r_req_if.sink      req_ch,
   c3r_rsp_if.source    rsp_ch,
   c3r_csr_if.sink      csr_ch
);

   logic [2:0][c3r_pkg::KROW_W-1:0] krow_ff;
   logic [c3r_pkg::WIDTH_W-1:0]     width_ff;
   logic [c3r_pkg::ROW_W-1:0]       height_ff;

   c3r_pkg::cfg_type cfg;
   c3r_pkg::s1_type  s1;
   logic             s1_take;
   logic             csr_wr;

   assign csr_ch.ready = 1'b1;
   assign csr_wr       = csr_ch.valid && csr_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         krow_ff   <= '0;
         width_ff  <= c3r_pkg::WIDTH_W'(c3r_pkg::WIDTH_RST);
         height_ff <= c3r_pkg::ROW_W'(c3r_pkg::HEIGHT_RST);
      end else if (csr_wr) begin
         unique case (c3r_pkg::csr_idx_type'(csr_ch.index))
            c3r_pkg::CSR_KROW_TOP: begin
               krow_ff[0] <= csr_ch.data[c3r_pkg::KROW_W-1:0];
            end
            c3r_pkg::CSR_KROW_MID: begin
               krow_ff[1] <= csr_ch.data[c3r_pkg::KROW_W-1:0];
            end
            c3r_pkg::CSR_KROW_BOT: begin
               krow_ff[2] <= csr_ch.data[c3r_pkg::KROW_W-1:0];
            end
            c3r_pkg::CSR_IMG_WIDTH: begin
               width_ff <= csr_ch.data[c3r_pkg::WIDTH_W-1:0];
            end
            c3r_pkg::CSR_IMG_HEIGHT: begin
               height_ff <= csr_ch.data[c3r_pkg::ROW_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      cfg.krow   = krow_ff;
      cfg.width  = width_ff;
      cfg.height = height_ff;
   end

   c3r_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .in_valid (req_ch.valid),
      .in_px    ({req_ch.pixel_chan2, req_ch.pixel_chan1, req_ch.pixel_chan0}),
      .in_ready (req_ch.ready),
      .s1_take  (s1_take),
      .s1       (s1)
   );

   c3r_core u_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .s1      (s1),
      .s1_take (s1_take),
      .rsp     (rsp_ch)
   );

`ifndef ASSERT_OFF
   a_accept_fills_s1: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> s1.valid)
      else $error("accepted item lost before first stage");

   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      s1.valid && !s1_take |=> s1.valid && $stable(s1.px) && $stable(s1.above))
      else $error("stalled first stage changed");

   a_frame_end_row_end: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.frame_end |-> rsp_ch.row_end)
      else $error("frame end without row end");
`endif

endmodule

/* src/c3r_ram.sv */
`timescale 1ns / 1ps

module c3r_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 24
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/c3r_front.sv */
`timescale 1ns / 1ps

module c3r_front (
   input  logic                      clock,
   input  logic                      reset,
   input  c3r_pkg::cfg_type          cfg,
   input  logic                      in_valid,
   input  logic [c3r_pkg::PIX_W-1:0] in_px,
   output logic                      in_ready,
   input  logic                      s1_take,
   output c3r_pkg::s1_type           s1
);

   localparam int AW = c3r_pkg::ADDR_W;
   localparam int WW = c3r_pkg::WIDTH_W;
   localparam int RW = c3r_pkg::ROW_W;
   localparam int PW = c3r_pkg::PIX_W;

   logic [WW-1:0] w_eff;
   logic [RW-1:0] h_eff;
   logic          wrap_col;
   logic [AW-1:0] col_cur;
   logic [RW-1:0] row_tmp;
   logic [RW-1:0] row_cur;
   logic          last_col;
   logic          last_row;
   logic          pass;
   logic          emit;
   logic          accept;
   logic          wr_en;
   logic          fwd_hit;
   logic [PW-1:0] ram_a_q;
   logic [PW-1:0] ram_b_q;
   logic [PW-1:0] above;
   logic [PW-1:0] above2;

   logic [AW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic          s1_v_ff;
   logic [PW-1:0] px_ff;
   logic [AW-1:0] addr_ff;
   logic          emit_ff, pass_ff, lc_ff, lr_ff;
   logic          fwd_ff;
   logic [PW-1:0] fwd_a_ff, fwd_b_ff;

   always_comb begin
      if (cfg.width == '0) begin
         w_eff = WW'(1);
      end else if (cfg.width > WW'(c3r_pkg::MAX_WIDTH)) begin
         w_eff = WW'(c3r_pkg::MAX_WIDTH);
      end else begin
         w_eff = cfg.width;
      end
      h_eff = (cfg.height == '0) ? RW'(1) : cfg.height;
   end

   always_comb begin
      wrap_col = WW'(col_ff) >= w_eff;
      col_cur  = wrap_col ? '0 : col_ff;
      row_tmp  = wrap_col ? row_ff + RW'(1) : row_ff;
      row_cur  = (row_tmp >= h_eff) ? '0 : row_tmp;
      last_col = (WW'(col_cur) + WW'(1)) == w_eff;
      last_row = ((RW + 1)'(row_cur) + (RW + 1)'(1)) == (RW + 1)'(h_eff);
      pass     = (w_eff < WW'(3)) || (h_eff < RW'(3));
      emit     = pass || ((row_cur >= RW'(2)) && (col_cur >= AW'(2)));
      if (last_col) begin
         col_in = '0;
         row_in = last_row ? '0 : row_cur + RW'(1);
      end else begin
         col_in = col_cur + AW'(1);
         row_in = row_cur;
      end
   end

   assign in_ready = !s1_v_ff || s1_take;
   assign accept   = in_valid && in_ready;
   assign wr_en    = s1_v_ff && s1_take;
   assign fwd_hit  = wr_en && (addr_ff == col_cur);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         s1_v_ff <= 1'b0;
      end else begin
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
         if (in_ready) begin
            s1_v_ff <= in_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         px_ff    <= in_px;
         addr_ff  <= col_cur;
         emit_ff  <= emit;
         pass_ff  <= pass;
         lc_ff    <= last_col;
         lr_ff    <= last_row;
         fwd_ff   <= fwd_hit;
         fwd_a_ff <= px_ff;
         fwd_b_ff <= above;
      end
   end

   c3r_ram #(.DEPTH(c3r_pkg::MAX_WIDTH), .WIDTH(PW)) u_line_a (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (addr_ff),
      .wr_data (px_ff),
      .rd_en   (accept),
      .rd_addr (col_cur),
      .rd_data (ram_a_q)
   );

   c3r_ram #(.DEPTH(c3r_pkg::MAX_WIDTH), .WIDTH(PW)) u_line_b (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (addr_ff),
      .wr_data (above),
      .rd_en   (accept),
      .rd_addr (col_cur),
      .rd_data (ram_b_q)
   );

   assign above  = fwd_ff ? fwd_a_ff : ram_a_q;
   assign above2 = fwd_ff ? fwd_b_ff : ram_b_q;

   always_comb begin
      s1.valid    = s1_v_ff;
      s1.px       = px_ff;
      s1.above    = above;
      s1.above2   = above2;
      s1.emit     = emit_ff;
      s1.pass     = pass_ff;
      s1.last_col = lc_ff;
      s1.last_row = lr_ff;
   end

endmodule

/* src/c3r_core.sv */
`timescale 1ns / 1ps

module c3r_core (
   input  logic             clock,
   input  logic             reset,
   input  c3r_pkg::cfg_type cfg,
   input  c3r_pkg::s1_type  s1,
   output logic             s1_take,
   c3r_rsp_if.source        rsp
);

   localparam int CW = c3r_pkg::CHAN_W;
   localparam int KB = c3r_pkg::COEF_BITS;
   localparam int SW = c3r_pkg::SUM_W;
   localparam int PRW = c3r_pkg::PROD_W;
   localparam int OW = c3r_pkg::OUT_W;

   logic [c3r_pkg::PIX_W-1:0] win_ff [9];
   logic                      s2_v_ff;
   logic                      s2_emit_ff, s2_pass_ff, s2_lc_ff, s2_lr_ff;
   logic                      rsp_v_ff;
   logic [OW-1:0]             out_ff [3];
   logic                      row_end_ff, frame_end_ff;

   logic                 out_free;
   logic                 s2_adv;
   logic                 out_load;
   logic signed [SW-1:0] sum [3];
   logic [OW-1:0]        rect [3];

   function automatic logic [OW-1:0] rectify(input logic signed [SW-1:0] s);
      logic signed [31:0] v;
      v = 32'(s);
      if (v > c3r_pkg::CLAMP_HI) begin
         v = c3r_pkg::CLAMP_HI;
      end
      if (v < c3r_pkg::CLAMP_LO) begin
         v = c3r_pkg::CLAMP_LO;
      end
      if (v < 0) begin
         v = '0;
      end
      return v[OW-1:0];
   endfunction

   assign out_free = !rsp_v_ff || rsp.ready;
   assign s2_adv   = s2_v_ff && (out_free || !s2_emit_ff);
   assign s1_take  = !s2_v_ff || s2_adv;
   assign out_load = s2_adv && s2_emit_ff;

   // kernel (i,j) times window row i, column j; row 0 and column 0 oldest
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sum[k] = '0;
         for (int t = 0; t < 9; t++) begin
            sum[k] = sum[k] + SW'(
               $signed(cfg.krow[t / 3][(t % 3) * KB +: KB])
               * $signed({1'b0, win_ff[t][k * CW +: CW]}));
         end
         rect[k] = rectify(sum[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff  <= 1'b0;
         rsp_v_ff <= 1'b0;
         for (int t = 0; t < 9; t++) begin
            win_ff[t] <= '0;
         end
      end else begin
         if (s1_take) begin
            s2_v_ff <= s1.valid;
         end
         if (s1_take && s1.valid) begin
            for (int i = 0; i < 3; i++) begin
               win_ff[i * 3]     <= win_ff[i * 3 + 1];
               win_ff[i * 3 + 1] <= win_ff[i * 3 + 2];
            end
            win_ff[2] <= s1.above2;
            win_ff[5] <= s1.above;
            win_ff[8] <= s1.px;
         end
         if (out_load) begin
            rsp_v_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_v_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_take && s1.valid) begin
         s2_emit_ff <= s1.emit;
         s2_pass_ff <= s1.pass;
         s2_lc_ff   <= s1.last_col;
         s2_lr_ff   <= s1.last_row;
      end
      if (out_load) begin
         for (int k = 0; k < 3; k++) begin
            out_ff[k] <= s2_pass_ff ? OW'(win_ff[8][k * CW +: CW]) : rect[k];
         end
         row_end_ff   <= s2_lc_ff;
         frame_end_ff <= s2_lc_ff && s2_lr_ff;
      end
   end

   assign rsp.valid     = rsp_v_ff;
   assign rsp.out_chan0 = out_ff[0];
   assign rsp.out_chan1 = out_ff[1];
   assign rsp.out_chan2 = out_ff[2];
   assign rsp.row_end   = row_end_ff;
   assign rsp.frame_end = frame_end_ff;

   // PRW documents the product width that SW is built on
   if (SW < PRW) begin : g_width_check
      $error("sum narrower than product");
   end

endmodule

/* dv/c3r_window_checker.sv */
`timescale 1ns / 1ps

module c3r_window_checker
   import c3r_pkg::*;
(
   input  logic clock,
   input  logic reset,
   c3r_req_if   req_ch,
   c3r_rsp_if   rsp_ch,
   c3r_csr_if   csr_ch,
   output int   mismatches,
   output int   results_due
);

   typedef struct packed {
      logic [2:0][OUT_W-1:0] chan;
      logic                  row_end;
      logic                  frame_end;
   } conv_result_type;

   logic [KROW_W-1:0]  krow [3];
   logic [WIDTH_W-1:0] width_reg;
   logic [ROW_W-1:0]   height_reg;
   logic [PIX_W-1:0]   row_above  [MAX_WIDTH];
   logic [PIX_W-1:0]   row_above2 [MAX_WIDTH];
   logic [PIX_W-1:0]   win [9];
   int unsigned        col_at;
   int unsigned        row_at;
   conv_result_type    conv_results_due [$];

   function automatic longint coef(int r, int c);
      logic signed [COEF_BITS-1:0] f;
      f = krow[r][c*COEF_BITS +: COEF_BITS];
      return longint'(f);
   endfunction

   function automatic void take_pixel(logic [CHAN_W-1:0] c0, c1, c2);
      int unsigned w, h, c, r;
      logic [PIX_W-1:0] px, up, up2;
      bit last_col, last_row;
      longint s;
      conv_result_type res;
      w = width_reg;
      h = height_reg;
      if (w == 0) w = 1;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      if (h == 0) h = 1;
      if (col_at >= w) begin
         col_at = 0;
         row_at++;
      end
      if (row_at >= h) row_at = 0;
      c = col_at;
      r = row_at;
      px = {c2, c1, c0};
      up = row_above[c];
      up2 = row_above2[c];
      for (int i = 0; i < 3; i++) begin
         win[i*3] = win[i*3+1];
         win[i*3+1] = win[i*3+2];
      end
      win[2] = up2;
      win[5] = up;
      win[8] = px;
      row_above2[c] = up;
      row_above[c] = px;
      last_col = (c + 1 == w);
      last_row = (r + 1 == h);
      col_at = c + 1;
      if (last_col) begin
         col_at = 0;
         row_at = last_row ? 0 : r + 1;
      end
      if (w < 3 || h < 3) begin
         res.chan[0] = OUT_W'(c0);
         res.chan[1] = OUT_W'(c1);
         res.chan[2] = OUT_W'(c2);
      end else if (r < 2 || c < 2) begin
         return;
      end else begin
         for (int k = 0; k < 3; k++) begin
            s = 0;
            for (int i = 0; i < 3; i++)
               for (int j = 0; j < 3; j++)
                  s += coef(i, j) * longint'(win[i*3+j][8*k +: 8]);
            if (s > longint'(CLAMP_HI)) s = longint'(CLAMP_HI);
            if (s < longint'(CLAMP_LO)) s = longint'(CLAMP_LO);
            if (s < 0) s = 0;
            res.chan[k] = s[OUT_W-1:0];
         end
      end
      res.row_end = last_col;
      res.frame_end = last_col && last_row;
      conv_results_due.push_back(res);
   endfunction

   always @(posedge clock) begin
      conv_result_type got, want;
      if (reset) begin
         for (int i = 0; i < 3; i++) krow[i] = '0;
         width_reg = WIDTH_W'(WIDTH_RST);
         height_reg = ROW_W'(HEIGHT_RST);
         for (int i = 0; i < MAX_WIDTH; i++) begin
            row_above[i] = '0;
            row_above2[i] = '0;
         end
         for (int i = 0; i < 9; i++) win[i] = '0;
         col_at = 0;
         row_at = 0;
         conv_results_due.delete();
         mismatches = 0;
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               CSR_KROW_TOP:   krow[0] = csr_ch.data[KROW_W-1:0];
               CSR_KROW_MID:   krow[1] = csr_ch.data[KROW_W-1:0];
               CSR_KROW_BOT:   krow[2] = csr_ch.data[KROW_W-1:0];
               CSR_IMG_WIDTH:  width_reg = csr_ch.data[WIDTH_W-1:0];
               CSR_IMG_HEIGHT: height_reg = csr_ch.data[ROW_W-1:0];
               default: ;
            endcase
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.chan[0] = rsp_ch.out_chan0;
            got.chan[1] = rsp_ch.out_chan1;
            got.chan[2] = rsp_ch.out_chan2;
            got.row_end = rsp_ch.row_end;
            got.frame_end = rsp_ch.frame_end;
            if (conv_results_due.size() == 0) begin
               $error("unexpected item: out_chan0 %0d out_chan1 %0d out_chan2 %0d",
                      got.chan[0], got.chan[1], got.chan[2]);
               mismatches++;
            end else begin
               want = conv_results_due.pop_front();
               for (int k = 0; k < 3; k++) begin
                  if (got.chan[k] !== want.chan[k]) begin
                     $error("out_chan%0d: expected %0d, got %0d", k, want.chan[k],
                            got.chan[k]);
                     mismatches++;
                  end
               end
               if (got.row_end !== want.row_end) begin
                  $error("row_end: expected %0d, got %0d", want.row_end, got.row_end);
                  mismatches++;
               end
               if (got.frame_end !== want.frame_end) begin
                  $error("frame_end: expected %0d, got %0d", want.frame_end,
                         got.frame_end);
                  mismatches++;
               end
            end
         end
         if (req_ch.valid && req_ch.ready)
            take_pixel(req_ch.pixel_chan0, req_ch.pixel_chan1, req_ch.pixel_chan2);
      end
      results_due = conv_results_due.size();
   end

endmodule

/* dv/tb_conv3x3_relu_rgb.sv */
`timescale 1ns / 1ps

module tb_conv3x3_relu_rgb;
   import c3r_pkg::*;

   typedef enum {PACE_FULL, PACE_SEND_IDLE, PACE_RECV_STALL, PACE_BOTH} pace_type;

   localparam int QUIET_LIMIT = 4000;
   localparam int RANDOM_PIXELS = 520;

   logic clock;
   logic reset;
   int   mismatches;
   int   results_due;
   int   send_idle_pct;
   int   recv_stall_pct;
   bit   hold_go;
   bit   hold_done;
   int   hold_left;
   int   quiet_cycles;
   int   random_pixels;
   int   phase_idx;

   c3r_req_if req_ch ();
   c3r_rsp_if rsp_ch ();
   c3r_csr_if csr_ch ();

   conv3x3_relu_rgb DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   c3r_window_checker u_window_check (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_ch      (csr_ch),
      .mismatches  (mismatches),
      .results_due (results_due)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // result side: random stalls plus one long hold-off
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left--;
      end else if (hold_go && !hold_done) begin
         hold_done = 1'b1;
         hold_left = 60;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
             (csr_ch.valid && csr_ch.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   function automatic void set_pace(pace_type p);
      case (p)
         PACE_FULL:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         PACE_SEND_IDLE:  begin send_idle_pct = 73; recv_stall_pct = 0;  end
         PACE_RECV_STALL: begin send_idle_pct = 0;  recv_stall_pct = 73; end
         default:         begin send_idle_pct = 8;  recv_stall_pct = 8;  end
      endcase
   endfunction

   function automatic logic [CHAN_W-1:0] rand_chan();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 10) return '0;
      if (r < 20) return '1;
      return CHAN_W'($urandom());
   endfunction

   function automatic logic [KROW_W-1:0] rand_krow();
      if ($urandom_range(99) < 50) return KROW_W'($urandom());
      return KROW_W'($urandom()) & 24'h7F7F7F;
   endfunction

   task automatic send_pixel(input logic [CHAN_W-1:0] c0, c1, c2);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.pixel_chan0 <= c0;
      req_ch.pixel_chan1 <= c1;
      req_ch.pixel_chan2 <= c2;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic send_random(input int n);
      for (int i = 0; i < n; i++) send_pixel(rand_chan(), rand_chan(), rand_chan());
      req_ch.valid <= 1'b0;
   endtask

   task automatic csr_write(input csr_idx_type idx, input logic [CSR_DATA_W-1:0] val);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= val;
      do @(posedge clock); while (!csr_ch.ready);
   endtask

   // wait for all results, then for any result-less item still in the pipe
   task automatic settle();
      do @(posedge clock); while (results_due != 0);
      repeat (8) @(posedge clock);
   endtask

   // a 1x1 pixel first puts the counters back to frame start, so the new
   // width never grows inside a running frame
   task automatic configure(input logic [KROW_W-1:0] k_top, k_mid, k_bot,
                            input logic [CSR_DATA_W-1:0] w_word, h_word);
      settle();
      csr_write(CSR_IMG_WIDTH, CSR_DATA_W'(1));
      csr_write(CSR_IMG_HEIGHT, CSR_DATA_W'(1));
      csr_ch.valid <= 1'b0;
      send_random(1);
      settle();
      csr_write(CSR_KROW_TOP, k_top);
      csr_write(CSR_KROW_MID, k_mid);
      csr_write(CSR_KROW_BOT, k_bot);
      csr_write(CSR_IMG_WIDTH, w_word);
      csr_write(CSR_IMG_HEIGHT, h_word);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic run_phase(input logic [KROW_W-1:0] k_top, k_mid, k_bot,
                            input logic [CSR_DATA_W-1:0] w_word, h_word,
                            input int n, input bit shrink);
      int unsigned ew, eh;
      ew = w_word[WIDTH_W-1:0];
      eh = h_word[ROW_W-1:0];
      if (ew == 0) ew = 1;
      if (ew > MAX_WIDTH) ew = MAX_WIDTH;
      if (eh == 0) eh = 1;
      configure(k_top, k_mid, k_bot, w_word, h_word);
      send_random(n);
      if (shrink) begin
         // size no larger than before, mid-frame: counters past the new size wrap
         settle();
         csr_write(CSR_IMG_WIDTH, CSR_DATA_W'($urandom_range(ew, 1)));
         csr_write(CSR_IMG_HEIGHT, CSR_DATA_W'($urandom_range(eh > 12 ? 12 : eh, 1)));
         csr_ch.valid <= 1'b0;
         send_random($urandom_range(30, 1));
      end
   endtask

   initial begin
      int unsigned w, h, n, r;
      logic [CSR_DATA_W-1:0] w_word, h_word;
      reset = 1'b1;
      hold_go = 1'b0;
      hold_done = 1'b0;
      hold_left = 0;
      random_pixels = 0;
      set_pace(PACE_FULL);
      req_ch.valid = 1'b0;
      req_ch.pixel_chan0 = '0;
      req_ch.pixel_chan1 = '0;
      req_ch.pixel_chan2 = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.index = CSR_KROW_TOP;
      csr_ch.data = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // largest positive sum
      configure(24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F, 24'd3, 24'd3);
      repeat (9) send_pixel(8'hFF, 8'hFF, 8'hFF);
      req_ch.valid <= 1'b0;
      // negative sum rectified to zero
      configure(24'h808080, 24'h808080, 24'h808080, 24'd3, 24'd3);
      repeat (9) send_pixel(8'hFF, 8'hFF, 8'hFF);
      req_ch.valid <= 1'b0;
      // zero width and height act as 1x1, pass-through
      configure(rand_krow(), rand_krow(), rand_krow(), 24'hFFF800, 24'hFF0000);
      send_pixel(8'h00, 8'hFF, 8'h00);
      send_pixel(8'hFF, 8'h00, 8'hFF);
      send_pixel(8'h00, 8'h00, 8'h00);
      req_ch.valid <= 1'b0;
      configure(rand_krow(), rand_krow(), rand_krow(), 24'd2, 24'd2);
      send_pixel(8'hFF, 8'hFF, 8'hFF);
      send_pixel(8'h00, 8'h00, 8'h00);
      send_pixel(8'h55, 8'hAA, 8'h55);
      send_pixel(8'hAA, 8'h55, 8'hAA);
      req_ch.valid <= 1'b0;

      // widest frame (width saturates) and tallest height
      set_pace(PACE_BOTH);
      run_phase(rand_krow(), rand_krow(), rand_krow(),
                {13'($urandom()), 11'h7FF}, {8'($urandom()), 16'd3}, 60, 1'b0);
      run_phase(rand_krow(), rand_krow(), rand_krow(),
                {13'($urandom()), 11'd3}, {8'($urandom()), 16'hFFFF}, 40, 1'b0);

      // long result hold-off while pixels keep coming
      set_pace(PACE_FULL);
      configure(24'h7F7F7F & KROW_W'($urandom()), rand_krow(), rand_krow(), 24'd4, 24'd30);
      hold_go = 1'b1;
      send_random(120);
      settle();

      phase_idx = 0;
      while (random_pixels < RANDOM_PIXELS) begin
         set_pace(pace_type'(phase_idx % 4));
         r = $urandom_range(99);
         if (r < 10) w = $urandom_range(2, 0);
         else if (r < 80) w = $urandom_range(8, 3);
         else if (r < 95) w = $urandom_range(40, 9);
         else w = $urandom_range(200, 41);
         r = $urandom_range(99);
         if (r < 10) h = $urandom_range(2, 0);
         else if (r < 85) h = $urandom_range(10, 3);
         else h = $urandom_range(40, 11);
         w_word = {13'($urandom()), 11'(w)};
         h_word = {8'($urandom()), 16'(h)};
         if (w == 0) w = 1;
         if (h == 0) h = 1;
         n = $urandom_range(2 * w * h, (w * h) / 2 + 1);
         if (n > 160) n = 160;
         run_phase(rand_krow(), rand_krow(), rand_krow(), w_word, h_word, n,
                   $urandom_range(99) < 40);
         random_pixels += n;
         phase_idx++;
      end

      do @(posedge clock); while (results_due != 0);
      repeat (10) @(posedge clock);
      if (mismatches == 0 && results_due == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
